/* hw/rtl/joystick_frame_encoder_defines.svh */
// Assertion macros shared by the joystick frame encoder RTL.
`ifndef JOYSTICK_FRAME_ENCODER_DEFINES_SVH
`define JOYSTICK_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define JFE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("joystick frame encoder: same-cycle check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define JFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("joystick frame encoder: next-cycle check failed");

`endif

/* hw/rtl/jfe_pkg.sv */
// Shared types, constants and helpers of the joystick frame encoder.
package jfe_pkg;

  // Switch positions
  localparam logic [1:0] SW_PARK   = 2'd0;
  localparam logic [1:0] SW_FWD    = 2'd1;
  localparam logic [1:0] SW_REV    = 2'd2;
  localparam logic [1:0] SW_UNUSED = 2'd3;

  // Direction codes sent in the frame
  localparam logic [1:0] DIR_FWD = 2'd2;
  localparam logic [1:0] DIR_REV = 2'd1;

  // Frame framing and fill bytes
  localparam logic [7:0] FRAME_MARK  = 8'hAA;
  localparam logic [7:0] SPD_HI_FILL = 8'h80;
  localparam logic [7:0] SPD_LO_FILL = 8'h01;

  // Speed axis thresholds
  localparam logic [7:0] Y_MID = 8'd130;
  localparam logic [7:0] Y_HI  = 8'd132;
  localparam logic [7:0] Y_LO  = 8'd128;

  // Scale factors: steering x*703/1000, speed *35, brake *19/10
  localparam logic [9:0]  STEER_NUM   = 10'd703;
  localparam logic [9:0]  STEER_DIV   = 10'd1000;
  localparam logic [10:0] STEER_RECIP = 11'd1048;  // floor(2^20/1000), under
  localparam logic [5:0]  SPD_GAIN    = 6'd35;
  localparam logic [4:0]  BRK_NUM     = 5'd19;
  localparam logic [3:0]  BRK_DIV     = 4'd10;
  localparam logic [7:0]  BRK_RECIP   = 8'd204;    // under 2^11/10

  // Payload queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Byte positions inside a frame
  localparam logic [2:0] BYTE_HEAD   = 3'd0;
  localparam logic [2:0] BYTE_DIR    = 3'd1;
  localparam logic [2:0] BYTE_SPD_HI = 3'd2;
  localparam logic [2:0] BYTE_SPD_LO = 3'd3;
  localparam logic [2:0] BYTE_STEER  = 3'd4;
  localparam logic [2:0] BYTE_BRAKE  = 3'd5;
  localparam logic [2:0] BYTE_TAIL   = 3'd6;

  // Five payload bytes of one frame
  typedef struct packed {
    logic [7:0] dir;
    logic [7:0] spd_hi;
    logic [7:0] spd_lo;
    logic [7:0] steer;
    logic [7:0] brake;
  } pay_t;

  // A zero byte goes out as one
  function automatic logic [7:0] nonzero(input logic [7:0] b);
    logic [7:0] r;
    r = (b == 8'd0) ? 8'd1 : b;
    return r;
  endfunction

endpackage

/* hw/rtl/joystick_frame_encoder.sv */
// Joystick frame encoder: one sample in, a seven-byte command frame out.
// The in_ channel takes one joystick sample per item; the out_ channel
// gives frame bytes, one per item, with tlast on the closing 0xAA byte.
// A sample passes three front stages (products, reciprocal quotients,
// correction and repeat check), then waits in a four-entry payload queue.
// A sample is registered in stage one and stage two, pushed into the queue,
// then loaded into the output register as the first frame byte.
// The serializer sends one byte per cycle while the receiver is ready;
// with the queue full, samples that send frames are taken only as frames
// leave it, while suppressed samples go through at one per cycle.
// When the receiver stalls, the output byte holds; the queue fills and
// then the front stops taking samples, while queued frames are kept.
// Reset clears the queue, the output register, the held direction
// (forward), the held brake (zero) and the last sent payload (zeros).
module joystick_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] x_sample, [15:8] y_sample, [17:16] switch_pos
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast   // frame_end
);

`include "joystick_frame_encoder_defines.svh"

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  jfe_pkg::pay_t q_in;
  jfe_pkg::pay_t q_out;

  // Sample intake and payload build
  jfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Payload queue
  jfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Frame serializer
  jfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks
  `JFE_ASSERT_SAME(a_no_push_when_full, q_push, !q_full)
  `JFE_ASSERT_SAME(a_no_pop_when_empty, q_pop, !q_empty)
  `JFE_ASSERT_SAME(a_tail_is_mark, out_tvalid && out_tlast, out_tdata == jfe_pkg::FRAME_MARK)
  `JFE_ASSERT_SAME(a_byte_nonzero, out_tvalid, out_tdata != 8'd0)

endmodule

/* hw/rtl/jfe_front.sv */
// Front end: accepts samples, computes payload bytes, drops repeated frames.
module jfe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [23:0]   in_tdata,
  input  logic          q_full,
  output logic          q_push,
  output jfe_pkg::pay_t q_data
);

  // Sample fields
  logic [7:0] x_in;
  logic [7:0] y_in;
  logic [1:0] sw_in;
  assign x_in  = in_tdata[7:0];
  assign y_in  = in_tdata[15:8];
  assign sw_in = in_tdata[17:16];

  // Stage one: products and speed
  logic        park_in;
  logic        fill_in;
  logic [1:0]  dir_in;
  logic [6:0]  y_ofs;
  logic [12:0] spd_fwd;
  logic [12:0] spd_in;
  logic [7:0]  brk_ofs;
  logic [11:0] brk_prod_in;
  logic [17:0] steer_prod_in;

  assign park_in = (sw_in == jfe_pkg::SW_PARK) || (sw_in == jfe_pkg::SW_UNUSED);
  assign fill_in = park_in || ((y_in >= jfe_pkg::Y_LO) && (y_in <= jfe_pkg::Y_HI));
  assign dir_in  = (sw_in == jfe_pkg::SW_REV) ? jfe_pkg::DIR_REV : jfe_pkg::DIR_FWD;
  assign y_ofs   = 7'(y_in - jfe_pkg::Y_MID);
  assign spd_fwd = {6'd0, y_ofs} * {7'd0, jfe_pkg::SPD_GAIN};

  always_comb begin
    if (park_in || (y_in <= jfe_pkg::Y_HI)) begin
      spd_in = 13'd0;
    end else if (sw_in == jfe_pkg::SW_REV) begin
      spd_in = spd_fwd >> 2;
    end else begin
      spd_in = spd_fwd;
    end
  end

  assign brk_ofs       = (y_in <= jfe_pkg::Y_MID) ? 8'(jfe_pkg::Y_MID - y_in) : 8'd0;
  assign brk_prod_in   = {4'd0, brk_ofs} * {7'd0, jfe_pkg::BRK_NUM};
  assign steer_prod_in = {10'd0, x_in} * {8'd0, jfe_pkg::STEER_NUM};

  // Pipeline control
  logic adv;
  logic v1_r, v2_r;
  logic send;

  assign adv       = !(v2_r && send && q_full);
  assign in_tready = adv;

  logic        s1_park_r, s1_fill_r;
  logic [1:0]  s1_dir_r;
  logic [12:0] s1_spd_r;
  logic [11:0] s1_brk_r;
  logic [17:0] s1_steer_r;

  logic        s2_park_r, s2_fill_r;
  logic [1:0]  s2_dir_r;
  logic [12:0] s2_spd_r;
  logic [11:0] s2_brk_r;
  logic [17:0] s2_steer_r;
  logic [7:0]  s2_brk_q_r;
  logic [7:0]  s2_steer_q_r;

  // Stage two: reciprocal estimates of the quotients
  logic [27:0] steer_est;
  logic [18:0] brk_est;
  assign steer_est = {10'd0, s1_steer_r} * {17'd0, jfe_pkg::STEER_RECIP};
  assign brk_est   = {7'd0, s1_brk_r} * {11'd0, jfe_pkg::BRK_RECIP};

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
  end

  // Advance stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_park_r    <= park_in;
      s1_fill_r    <= fill_in;
      s1_dir_r     <= dir_in;
      s1_spd_r     <= spd_in;
      s1_brk_r     <= brk_prod_in;
      s1_steer_r   <= steer_prod_in;
      s2_park_r    <= s1_park_r;
      s2_fill_r    <= s1_fill_r;
      s2_dir_r     <= s1_dir_r;
      s2_spd_r     <= s1_spd_r;
      s2_brk_r     <= s1_brk_r;
      s2_steer_r   <= s1_steer_r;
      s2_brk_q_r   <= brk_est[18:11];
      s2_steer_q_r <= steer_est[27:20];
    end
  end

  // Stage three: correct the quotients by one where needed
  logic [17:0] steer_rem;
  logic [11:0] brk_rem;
  logic [7:0]  steer_c;
  logic [7:0]  brk_c;
  assign steer_rem = s2_steer_r - ({10'd0, s2_steer_q_r} * {8'd0, jfe_pkg::STEER_DIV});
  assign brk_rem   = s2_brk_r - ({4'd0, s2_brk_q_r} * {8'd0, jfe_pkg::BRK_DIV});
  assign steer_c   = (steer_rem >= {8'd0, jfe_pkg::STEER_DIV}) ? 8'(s2_steer_q_r + 8'd1)
                                                              : s2_steer_q_r;
  assign brk_c     = (brk_rem >= {8'd0, jfe_pkg::BRK_DIV}) ? 8'(s2_brk_q_r + 8'd1)
                                                          : s2_brk_q_r;

  // Held state and last sent payload
  logic [1:0]    held_dir_r;
  logic [7:0]    held_brake_r;
  jfe_pkg::pay_t last_r;

  logic [1:0]    eff_dir;
  logic [7:0]    eff_brake;
  logic [7:0]    spd_hi_raw;
  jfe_pkg::pay_t pay;

  assign eff_dir    = s2_park_r ? held_dir_r : s2_dir_r;
  assign eff_brake  = s2_park_r ? held_brake_r : brk_c;
  assign spd_hi_raw = {3'd0, s2_spd_r[12:8]};

  // Build the payload
  always_comb begin
    pay.dir    = jfe_pkg::nonzero({6'd0, eff_dir});
    pay.steer  = jfe_pkg::nonzero(steer_c);
    pay.brake  = jfe_pkg::nonzero(eff_brake);
    if (s2_fill_r) begin
      pay.spd_hi = jfe_pkg::SPD_HI_FILL;
      pay.spd_lo = jfe_pkg::SPD_LO_FILL;
    end else begin
      pay.spd_hi = (spd_hi_raw == 8'd0) ? jfe_pkg::SPD_HI_FILL : spd_hi_raw;
      pay.spd_lo = jfe_pkg::nonzero(s2_spd_r[7:0]);
    end
  end

  assign send   = s2_park_r || (pay != last_r);
  assign q_push = v2_r && send && !q_full;
  assign q_data = pay;

  // Update held state and remember the sent payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_dir_r   <= jfe_pkg::DIR_FWD;
      held_brake_r <= 8'd0;
      last_r       <= '0;
    end else if (v2_r && adv) begin
      if (!s2_park_r) begin
        held_dir_r   <= s2_dir_r;
        held_brake_r <= brk_c;
      end
      if (send) begin
        last_r <= pay;
      end
    end
  end

endmodule

/* hw/rtl/jfe_queue.sv */
// Short payload queue between the front end and the byte serializer.
module jfe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jfe_pkg::pay_t push_data,
  input  logic          pop,
  output jfe_pkg::pay_t pop_data,
  output logic          empty,
  output logic          full
);

  localparam int CNT_W = $clog2(jfe_pkg::QUEUE_DEPTH + 1);

  jfe_pkg::pay_t                 slot_r [jfe_pkg::QUEUE_DEPTH];
  logic [jfe_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]              count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(jfe_pkg::QUEUE_DEPTH));
  assign pop_data = slot_r[rd_ptr_r];

  // Store pushed payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + jfe_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + jfe_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/jfe_back.sv */
// Back end: sends each queued payload as a seven-byte frame.
module jfe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jfe_pkg::pay_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic [7:0] byte_sel;

  assign load       = !valid_r || out_tready;
  assign q_pop      = load && !q_empty && (idx_r == jfe_pkg::BYTE_TAIL);
  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  // Pick the frame byte at the current position
  always_comb begin
    case (idx_r)
      jfe_pkg::BYTE_HEAD:   byte_sel = jfe_pkg::FRAME_MARK;
      jfe_pkg::BYTE_DIR:    byte_sel = q_data.dir;
      jfe_pkg::BYTE_SPD_HI: byte_sel = q_data.spd_hi;
      jfe_pkg::BYTE_SPD_LO: byte_sel = q_data.spd_lo;
      jfe_pkg::BYTE_STEER:  byte_sel = q_data.steer;
      jfe_pkg::BYTE_BRAKE:  byte_sel = q_data.brake;
      jfe_pkg::BYTE_TAIL:   byte_sel = jfe_pkg::FRAME_MARK;
      default:              byte_sel = jfe_pkg::FRAME_MARK;
    endcase
  end

  // Load the output register and step through the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= jfe_pkg::BYTE_HEAD;
    end else if (load) begin
      valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= (idx_r == jfe_pkg::BYTE_TAIL) ? jfe_pkg::BYTE_HEAD : 3'(idx_r + 3'd1);
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_sel;
      last_r <= (idx_r == jfe_pkg::BYTE_TAIL);
    end
  end

endmodule
